@@ design/assert_macros.svh @@
// Assertion helpers used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define HED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hed check failed");

// Checked on every rising edge, reset included.
`define HED_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hed check failed");

`endif

@@ design/hed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_pkg
// Entity table, shared types and sizes for the HTML entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int ENT_NUM     = 6;
  localparam int ENT_MAX_LEN = 7;
  localparam int CELL_NUM    = 7;   // six held bytes plus the incoming one

  localparam logic [7:0] CH_AMP = 8'h26;

  // Entity text, padded with zeros past its length.
  localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAX_LEN] = '{
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},  // &lt;
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00},  // &amp;
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00},  // &quot;
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B, 8'h00},  // &apos;
    '{8'h26, 8'h66, 8'h72, 8'h61, 8'h73, 8'h6C, 8'h3B}   // &frasl;
  };

  localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd7};

  localparam logic [7:0] ENT_SYM [ENT_NUM] = '{8'h3E, 8'h3C, 8'h26, 8'h22, 8'h27, 8'h2F};

  // What an accepted word does to the chain.
  typedef enum logic [2:0] {
    ACT_NEW_AMP,    // flush held bytes, hold the new '&'
    ACT_DECODE,     // entity complete, emit its symbol
    ACT_EXTEND,     // still a prefix, hold one more byte
    ACT_MISMATCH,   // emit held bytes and the new byte
    ACT_PASS        // nothing held, emit the byte
  } hed_act_t;

  typedef struct packed {
    logic                 full;
    logic                 prefix;
    logic [7:0]           sym;
    logic [ENT_NUM-1:0]   alive_nxt;
  } hed_match_t;

  typedef struct packed {
    logic shift;
    logic load_c;
    logic load_sym;
  } hed_cell_ctl_t;

endpackage

@@ design/hed_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_cell
// One byte slot of the hold/flush chain; shifts toward slot zero.
// ----------------------------------------------------------------------------
module hed_cell (
  input  logic                   clk,
  input  hed_pkg::hed_cell_ctl_t ctl,
  input  logic [7:0]             right_byte,
  input  logic [7:0]             new_byte,
  input  logic [7:0]             sym_byte,
  output logic [7:0]             cell_byte
);
  import hed_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    priority if (ctl.load_sym) begin
      byte_nxt = sym_byte;
    end else if (ctl.load_c) begin
      byte_nxt = new_byte;
    end else if (ctl.shift) begin
      byte_nxt = right_byte;
    end else begin
      byte_nxt = byte_r;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign cell_byte = byte_r;

endmodule

@@ design/hed_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_match
// Compares one new byte against every entity still alive at this position.
// ----------------------------------------------------------------------------
module hed_match (
  input  logic [hed_pkg::ENT_NUM-1:0] alive,
  input  logic [2:0]                  pos,
  input  logic [7:0]                  ch,
  output hed_pkg::hed_match_t         res
);
  import hed_pkg::*;

  logic [ENT_NUM-1:0] hit;
  logic [ENT_NUM-1:0] done;
  logic [2:0]         pos_inc;
  logic [7:0]         sym;

  assign pos_inc = 3'(pos + 3'd1);

  always_comb begin
    sym = 8'h00;
    for (int e = 0; e < ENT_NUM; e++) begin
      hit[e]  = alive[e] && (pos < ENT_LEN[e]) && (ENT_TEXT[e][pos] == ch);
      done[e] = hit[e] && (pos_inc == ENT_LEN[e]);
      if (done[e]) begin
        sym = sym | ENT_SYM[e];
      end
    end
  end

  assign res.full      = |done;
  assign res.prefix    = |(hit & ~done);
  assign res.sym       = sym;
  assign res.alive_nxt = hit & ~done;

endmodule

@@ design/html_entity_decoder_top.sv @@
`timescale 1ns / 1ps
// Result words leave the byte chain through a single output register, which
// raises out_valid. Throughput: one word per cycle while out_ready holds; an
// item yielding k words blocks input until its last word shifts out. Items
// that only extend a held prefix yield no word and never block input, unless
// in_end_of_text is set. Reset (rst_n low, synchronous) empties the chain
// counts and the output register; held byte contents are not cleared.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// html_entity_decoder_top
// Decodes &gt; &lt; &amp; &quot; &apos; &frasl; in a byte stream.
// ----------------------------------------------------------------------------
module html_entity_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_text_done
);
  import hed_pkg::*;

  logic [2:0]         cnt_r,   cnt_nxt;
  logic [2:0]         drain_r, drain_nxt;
  logic               eot_r,   eot_nxt;
  logic [ENT_NUM-1:0] alive_r, alive_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r;
  logic               out_last_r;
  logic               out_done_r;

  logic       shifting;
  logic       accept;
  logic [2:0] n_base;
  logic [2:0] n_inc;
  hed_act_t   act;
  hed_match_t m;

  hed_cell_ctl_t cell_ctl [CELL_NUM];
  logic [7:0]    cell_q   [CELL_NUM];

  assign shifting = (drain_r != 3'd0) && (!out_valid_r || out_ready);
  assign in_ready = (drain_r == 3'd0) || ((drain_r == 3'd1) && shifting);
  assign accept   = in_valid && in_ready;
  assign n_base   = shifting ? 3'(cnt_r - 3'd1) : cnt_r;
  assign n_inc    = 3'(n_base + 3'd1);

  hed_match u_match (
    .alive (alive_r),
    .pos   (n_base),
    .ch    (in_char),
    .res   (m)
  );

  always_comb begin
    priority if (in_char == CH_AMP) begin
      act = ACT_NEW_AMP;
    end else if (n_base != 3'd0 && m.full) begin
      act = ACT_DECODE;
    end else if (n_base != 3'd0 && m.prefix && n_base < 3'(CELL_NUM - 1)) begin
      act = ACT_EXTEND;
    end else if (n_base != 3'd0) begin
      act = ACT_MISMATCH;
    end else begin
      act = ACT_PASS;
    end
  end

  always_comb begin
    cnt_nxt   = n_base;
    drain_nxt = shifting ? 3'(drain_r - 3'd1) : drain_r;
    eot_nxt   = eot_r;
    alive_nxt = alive_r;
    if (accept) begin
      eot_nxt = in_end_of_text;
      unique case (act)
        ACT_NEW_AMP: begin
          cnt_nxt   = n_inc;
          drain_nxt = in_end_of_text ? n_inc : n_base;
          alive_nxt = '1;
        end
        ACT_DECODE: begin
          cnt_nxt   = 3'd1;
          drain_nxt = 3'd1;
        end
        ACT_EXTEND: begin
          cnt_nxt   = n_inc;
          drain_nxt = in_end_of_text ? n_inc : 3'd0;
          alive_nxt = m.alive_nxt;
        end
        ACT_MISMATCH: begin
          cnt_nxt   = n_inc;
          drain_nxt = n_inc;
        end
        ACT_PASS: begin
          cnt_nxt   = 3'd1;
          drain_nxt = 3'd1;
        end
        default: begin
          cnt_nxt   = n_base;
        end
      endcase
    end
  end

  // Append the new byte right after the surviving held bytes, or load the decoded symbol into cell zero.
  always_comb begin
    for (int k = 0; k < CELL_NUM; k++) begin
      cell_ctl[k].shift    = shifting;
      cell_ctl[k].load_c   = accept && (act != ACT_DECODE) && (n_base == 3'(k));
      cell_ctl[k].load_sym = accept && (act == ACT_DECODE) && (k == 0);
    end
  end

  for (genvar k = 0; k < CELL_NUM; k++) begin : g_cell
    logic [7:0] right_byte;
    if (k == CELL_NUM - 1) begin : g_end
      assign right_byte = 8'h00;
    end else begin : g_mid
      assign right_byte = cell_q[k+1];
    end
    hed_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[k]),
      .right_byte (right_byte),
      .new_byte   (in_char),
      .sym_byte   (m.sym),
      .cell_byte  (cell_q[k])
    );
  end

  always_comb begin
    if (shifting) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      drain_r     <= 3'd0;
      eot_r       <= 1'b0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      drain_r     <= drain_nxt;
      eot_r       <= eot_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output word follows cell zero as the chain advances.
  always_ff @(posedge clk) begin
    if (shifting) begin
      out_char_r <= cell_q[0];
      out_last_r <= (drain_r == 3'd1);
      out_done_r <= (drain_r == 3'd1) && eot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;
  assign out_text_done   = out_done_r;

  `HED_ASSERT(a_drain_le_cnt, drain_r <= cnt_r)
  `HED_ASSERT(a_held_fits, 3'(cnt_r - drain_r) <= 3'(CELL_NUM - 1))
  `HED_ASSERT(a_done_is_last, out_valid && out_text_done |-> out_last_of_run)
  `HED_ASSERT(a_eot_empties, accept && in_end_of_text |=> cnt_r == drain_r)
  `HED_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && drain_r == 3'd0)

endmodule
